FILE: src/occupancy_grid_ray_update_defines.svh
// Shared assertion macros for the occupancy grid block.
// Every macro samples on the rising edge of clock and stays quiet in reset.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH

// Same-cycle implication.
`define OGR_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define OGR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: src/ogr_pkg.sv
`default_nettype none
package ogr_pkg;

   localparam int MAX_WIDTH       = 256;
   localparam int MAX_HEIGHT      = 256;
   localparam int MAX_GROW_POINTS = 16;

   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int XC_W   = $clog2(MAX_WIDTH);
   localparam int YC_W   = $clog2(MAX_HEIGHT);
   localparam int DIM_W  = 9;
   localparam int PAT_W  = 3;
   localparam int COORD_W = 13;
   localparam int POS_W  = 15;
   localparam int ERR_W  = 16;
   localparam int GI_W   = $clog2(MAX_GROW_POINTS);
   localparam int GC_W   = GI_W + 1;

   typedef logic [1:0] cell_type;
   localparam cell_type CELL_FREE        = 2'd0;
   localparam cell_type CELL_OBSTACLE    = 2'd1;
   localparam cell_type CELL_GROWING     = 2'd2;
   localparam cell_type CELL_UNDELETABLE = 2'd3;

   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_RAY     = 2'd1;
   localparam logic [1:0] ACT_CONVERT = 2'd2;
   localparam logic [1:0] ACT_READ    = 2'd3;

   localparam logic [PAT_W-1:0] PAT_NONE     = 3'd0;
   localparam logic [PAT_W-1:0] PAT_CIRCLE16 = 3'd1;
   localparam logic [PAT_W-1:0] PAT_STAR16   = 3'd2;
   localparam logic [PAT_W-1:0] PAT_STAR12   = 3'd3;
   localparam logic [PAT_W-1:0] PAT_CIRCLE8  = 3'd4;

   localparam logic [1:0] REG_WIDTH   = 2'd0;
   localparam logic [1:0] REG_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_PATTERN = 2'd2;

   localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);
   localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(256);

   typedef logic signed [3:0] goff_type;
   typedef goff_type gtab_type [16];

   localparam gtab_type C16_DX = '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};
   localparam gtab_type C16_DY = '{0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1};
   localparam gtab_type S16_DX = '{4, -4, -4, 4, 3, -3, -3, 3, 2, -2, -2, 2, 1, -1, -1, 1};
   localparam gtab_type S16_DY = '{4, 4, -4, -4, 3, 3, -3, -3, 2, 2, -2, -2, 1, 1, -1, -1};
   localparam gtab_type S12_DX = '{3, -3, -3, 3, 2, -2, -2, 2, 1, -1, -1, 1, 0, 0, 0, 0};
   localparam gtab_type S12_DY = '{3, 3, -3, -3, 2, 2, -2, -2, 1, 1, -1, -1, 0, 0, 0, 0};
   localparam gtab_type C8_DX  = '{2, 1, 0, -1, -2, -1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0};
   localparam gtab_type C8_DY  = '{0, 1, 2, 1, 0, -1, -2, -1, 0, 0, 0, 0, 0, 0, 0, 0};

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [PAT_W-1:0] pattern;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      cell_type          wdata;
   } mem_req_type;

   function automatic logic [GC_W-1:0] grow_count(input logic [PAT_W-1:0] p);
      logic [GC_W-1:0] c;
      case (p)
         PAT_CIRCLE16: c = GC_W'(16);
         PAT_STAR16:   c = GC_W'(16);
         PAT_STAR12:   c = GC_W'(12);
         PAT_CIRCLE8:  c = GC_W'(8);
         default:      c = '0;
      endcase
      if (c > GC_W'(MAX_GROW_POINTS)) c = GC_W'(MAX_GROW_POINTS);
      return c;
   endfunction

   function automatic goff_type grow_dx(input logic [PAT_W-1:0] p, input logic [3:0] i);
      goff_type d;
      case (p)
         PAT_CIRCLE16: d = C16_DX[i];
         PAT_STAR16:   d = S16_DX[i];
         PAT_STAR12:   d = S12_DX[i];
         PAT_CIRCLE8:  d = C8_DX[i];
         default:      d = '0;
      endcase
      return d;
   endfunction

   function automatic goff_type grow_dy(input logic [PAT_W-1:0] p, input logic [3:0] i);
      goff_type d;
      case (p)
         PAT_CIRCLE16: d = C16_DY[i];
         PAT_STAR16:   d = S16_DY[i];
         PAT_STAR12:   d = S12_DY[i];
         PAT_CIRCLE8:  d = C8_DY[i];
         default:      d = '0;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

FILE: src/ogr_csr.sv
`default_nettype none
module ogr_csr import ogr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [PAT_W-1:0] pattern_ff, pattern_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      pattern_in = pattern_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_WIDTH:   width_in   = pwdata[DIM_W-1:0];
            REG_HEIGHT:  height_in  = pwdata[DIM_W-1:0];
            REG_PATTERN: pattern_in = pwdata[PAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_RESET;
         height_ff  <= DIM_RESET;
         pattern_ff <= PAT_NONE;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         pattern_ff <= pattern_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WIDTH:   prdata = 32'(width_ff);
         REG_HEIGHT:  prdata = 32'(height_ff);
         REG_PATTERN: prdata = 32'(pattern_ff);
         default:     prdata = '0;
      endcase
   end

   // clamp size into the supported range
   always_comb begin
      cfg.width   = (width_ff < DIM_MIN) ? DIM_MIN :
                    (width_ff > WIDTH_MAX) ? WIDTH_MAX : width_ff;
      cfg.height  = (height_ff < DIM_MIN) ? DIM_MIN :
                    (height_ff > HEIGHT_MAX) ? HEIGHT_MAX : height_ff;
      cfg.pattern = pattern_ff;
   end

endmodule
`default_nettype wire

FILE: src/ogr_map_ram.sv
`default_nettype none
module ogr_map_ram import ogr_pkg::*; (
   input  wire logic  clock,
   input  mem_req_type req,
   output cell_type   rdata
);

   cell_type cells_mem [MAX_WIDTH*MAX_HEIGHT];
   cell_type rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) cells_mem[req.addr] <= req.wdata;
      if (req.re) rdata_ff <= cells_mem[req.addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: src/ogr_seq.sv
`default_nettype none
`include "occupancy_grid_ray_update_defines.svh"
module ogr_seq import ogr_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  cfg_type                 cfg,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         action,
   input  wire logic signed [COORD_W-1:0] start_x,
   input  wire logic signed [COORD_W-1:0] start_y,
   input  wire logic signed [COORD_W-1:0] end_x,
   input  wire logic signed [COORD_W-1:0] end_y,
   output mem_req_type             mem_req,
   input  cell_type                mem_rdata,
   output logic                    rsp_strobe,
   output cell_type                rsp_value
);

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_CONV_RD, S_CONV_WR, S_RAY_ACC, S_RAY_CHK, S_RAY_STEP,
      S_STAMP, S_STAMP_ACC, S_STAMP_CHK, S_RD_ACC, S_RD_DATA
   } state_type;

   state_type state_ff;
   logic [XC_W-1:0]   cx_ff;
   logic [YC_W-1:0]   cy_ff;
   logic [ADDR_W-1:0] lin_ff;
   logic signed [POS_W-1:0] px_ff, py_ff;
   logic signed [POS_W-1:0] ex_ff, ey_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff, n_ff, k_ff;
   logic              yneg_ff;
   cell_type          first_ff, last_ff;
   logic [GC_W-1:0]   si_ff;
   logic              strobe_ff;
   cell_type          value_ff;

   logic signed [POS_W-1:0] wpos, hpos;
   logic interior, inbound, k_first, k_last, sweep_end, border;
   logic [XC_W+DIM_W-1:0] prod;
   logic [ADDR_W-1:0] cell_addr;

   // ray setup from the incoming word
   logic signed [COORD_W:0] ddx, ddy;
   logic [COORD_W-1:0] adx, ady, an;
   logic lr;

   // one Bresenham step
   logic signed [ERR_W-1:0] e1, e2, dxs, dys;
   logic xadv, ystep;
   logic [GC_W-1:0] gcount;

   assign wpos = signed'(POS_W'(cfg.width));
   assign hpos = signed'(POS_W'(cfg.height));

   assign interior = px_ff > 0 && px_ff < wpos - 1 && py_ff > 0 && py_ff < hpos - 1;
   assign inbound  = px_ff >= 0 && px_ff < wpos && py_ff >= 0 && py_ff < hpos;
   assign k_first  = k_ff == '0;
   assign k_last   = k_ff == n_ff;

   assign prod      = py_ff[YC_W-1:0] * cfg.width;
   assign cell_addr = ADDR_W'(prod) + ADDR_W'(px_ff[XC_W-1:0]);

   assign sweep_end = DIM_W'(cx_ff) == cfg.width - 1 && DIM_W'(cy_ff) == cfg.height - 1;
   assign border    = cx_ff == '0 || DIM_W'(cx_ff) == cfg.width - 1 ||
                      cy_ff == '0 || DIM_W'(cy_ff) == cfg.height - 1;

   assign ddx = (COORD_W+1)'(start_x) - (COORD_W+1)'(end_x);
   assign ddy = (COORD_W+1)'(start_y) - (COORD_W+1)'(end_y);
   assign adx = ddx[COORD_W] ? COORD_W'(-ddx) : COORD_W'(ddx);
   assign ady = ddy[COORD_W] ? COORD_W'(-ddy) : COORD_W'(ddy);
   assign an  = (adx > ady) ? adx : ady;
   assign lr  = start_x < end_x;

   assign dxs   = signed'(ERR_W'(dx_ff));
   assign dys   = signed'(ERR_W'(dy_ff));
   assign xadv  = err_ff < dxs;
   assign e1    = xadv ? err_ff + dys : err_ff;
   assign ystep = e1 >= dxs;
   assign e2    = ystep ? e1 - dxs : e1;

   assign gcount = grow_count(cfg.pattern);

   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.re    = 1'b0;
      mem_req.addr  = cell_addr;
      mem_req.wdata = CELL_FREE;
      case (state_ff)
         S_CLR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = lin_ff;
            mem_req.wdata = border ? CELL_UNDELETABLE : CELL_FREE;
         end
         S_CONV_RD: begin
            mem_req.re   = 1'b1;
            mem_req.addr = lin_ff;
         end
         S_CONV_WR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = lin_ff;
            mem_req.wdata = border ? CELL_UNDELETABLE :
                            (mem_rdata == CELL_GROWING) ? CELL_OBSTACLE : mem_rdata;
         end
         S_RAY_ACC: begin
            if (interior) begin
               if (k_first || k_last) begin
                  mem_req.we    = 1'b1;
                  mem_req.wdata = k_first ? first_ff : last_ff;
               end else begin
                  mem_req.re = 1'b1;
               end
            end
         end
         S_RAY_CHK: begin
            mem_req.we = mem_rdata != CELL_GROWING && mem_rdata != CELL_UNDELETABLE;
         end
         S_STAMP_ACC: mem_req.re = inbound;
         S_STAMP_CHK: begin
            mem_req.we    = mem_rdata != CELL_UNDELETABLE;
            mem_req.wdata = CELL_GROWING;
         end
         S_RD_ACC: mem_req.re = inbound;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cx_ff  <= '0;
                  cy_ff  <= '0;
                  lin_ff <= '0;
                  k_ff   <= '0;
                  ex_ff  <= POS_W'(end_x);
                  ey_ff  <= POS_W'(end_y);
                  case (action)
                     ACT_CLEAR:   state_ff <= S_CLR;
                     ACT_CONVERT: state_ff <= S_CONV_RD;
                     ACT_RAY: begin
                        dx_ff  <= adx;
                        dy_ff  <= ady;
                        n_ff   <= an;
                        err_ff <= signed'(ERR_W'(an >> 1));
                        if (lr) begin
                           px_ff    <= POS_W'(start_x);
                           py_ff    <= POS_W'(start_y);
                           first_ff <= CELL_FREE;
                           last_ff  <= CELL_OBSTACLE;
                           yneg_ff  <= start_y > end_y;
                        end else begin
                           px_ff    <= POS_W'(end_x);
                           py_ff    <= POS_W'(end_y);
                           first_ff <= CELL_OBSTACLE;
                           last_ff  <= CELL_FREE;
                           yneg_ff  <= end_y > start_y;
                        end
                        state_ff <= S_RAY_ACC;
                     end
                     default: begin
                        px_ff    <= POS_W'(start_x);
                        py_ff    <= POS_W'(start_y);
                        state_ff <= S_RD_ACC;
                     end
                  endcase
               end
            end
            S_CLR, S_CONV_WR: begin
               if (sweep_end) begin
                  strobe_ff <= 1'b1;
                  value_ff  <= CELL_FREE;
                  state_ff  <= S_IDLE;
               end else begin
                  lin_ff <= lin_ff + 1'b1;
                  if (DIM_W'(cx_ff) == cfg.width - 1) begin
                     cx_ff <= '0;
                     cy_ff <= cy_ff + 1'b1;
                  end else begin
                     cx_ff <= cx_ff + 1'b1;
                  end
                  state_ff <= (state_ff == S_CLR) ? S_CLR : S_CONV_RD;
               end
            end
            S_CONV_RD: state_ff <= S_CONV_WR;
            S_RAY_ACC: begin
               if (interior && !k_first && !k_last) begin
                  state_ff <= S_RAY_CHK;
               end else if (k_last) begin
                  si_ff    <= '0;
                  state_ff <= S_STAMP;
               end else begin
                  state_ff <= S_RAY_STEP;
               end
            end
            S_RAY_CHK: state_ff <= S_RAY_STEP;
            S_RAY_STEP: begin
               err_ff <= e2;
               if (xadv) px_ff <= px_ff + 1'b1;
               if (ystep) py_ff <= yneg_ff ? py_ff - 1'b1 : py_ff + 1'b1;
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_RAY_ACC;
            end
            S_STAMP: begin
               if (si_ff >= gcount) begin
                  strobe_ff <= 1'b1;
                  value_ff  <= CELL_FREE;
                  state_ff  <= S_IDLE;
               end else begin
                  px_ff    <= ex_ff + POS_W'(grow_dx(cfg.pattern, si_ff[3:0]));
                  py_ff    <= ey_ff + POS_W'(grow_dy(cfg.pattern, si_ff[3:0]));
                  state_ff <= S_STAMP_ACC;
               end
            end
            S_STAMP_ACC: begin
               if (inbound) begin
                  state_ff <= S_STAMP_CHK;
               end else begin
                  si_ff    <= si_ff + 1'b1;
                  state_ff <= S_STAMP;
               end
            end
            S_STAMP_CHK: begin
               si_ff    <= si_ff + 1'b1;
               state_ff <= S_STAMP;
            end
            S_RD_ACC: begin
               if (inbound) begin
                  state_ff <= S_RD_DATA;
               end else begin
                  strobe_ff <= 1'b1;
                  value_ff  <= CELL_FREE;
                  state_ff  <= S_IDLE;
               end
            end
            S_RD_DATA: begin
               strobe_ff <= 1'b1;
               value_ff  <= mem_rdata;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_value  = value_ff;

   `OGR_ASSERT_NOW(a_one_port_op, mem_req.we, !mem_req.re, "read and write in one cycle")
   `OGR_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy, "result shown while busy")
   `OGR_ASSERT_NEXT(a_start_busy, start && !busy, busy || rsp_strobe, "command dropped")
   `OGR_ASSERT_NEXT(a_read_used, mem_req.re,
      state_ff == S_CONV_WR || state_ff == S_RAY_CHK ||
      state_ff == S_STAMP_CHK || state_ff == S_RD_DATA, "read data unused")

endmodule
`default_nettype wire

FILE: src/occupancy_grid_ray_update.sv
`default_nettype none
// Channel   Direction  Handshake                       Payload
// command   in         start && !busy                  req_action, req_start_x/y, req_end_x/y
// result    out        rsp_strobe, one cycle, no stall rsp_cell_value, rsp_op_done
// csr       in/out     APB, pready always high         width, height, growth pattern
//
// Work per command (W x H is the clamped grid size, N = max(|dx|,|dy|)):
//   clear   one write per cell, border written in the same sweep
//   convert read then write back per cell through the single RAM port
//   ray     walks the N+1 line cells, then stamps each growth point
//   read    one read of the cell, none when it is out of bounds
// All accesses share the single-port cell RAM. Reset is synchronous and clears
// control only; the cell store holds garbage until the first clear. The result
// word is registered and the receiver cannot stall it.
module occupancy_grid_ray_update import ogr_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [1:0]                req_action,
   input  wire logic signed [COORD_W-1:0] req_start_x,
   input  wire logic signed [COORD_W-1:0] req_start_y,
   input  wire logic signed [COORD_W-1:0] req_end_x,
   input  wire logic signed [COORD_W-1:0] req_end_y,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_cell_value,
   output logic                           rsp_op_done,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [3:0]                paddr,
   input  wire logic [31:0]               pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   cfg_type     cfg;
   mem_req_type mem_req;
   cell_type    mem_rdata;
   cell_type    rsp_value;

   // hold size and growth pattern
   ogr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sweep, walk the ray and stamp growth
   ogr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .start      (start),
      .busy       (busy),
      .action     (req_action),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value)
   );

   // cell store, addressed as x + y*width
   ogr_map_ram u_ram (
      .clock (clock),
      .req   (mem_req),
      .rdata (mem_rdata)
   );

   assign rsp_cell_value = rsp_value;
   assign rsp_op_done    = 1'b1;

endmodule
`default_nettype wire
